[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and sizes for the sorted priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Queue size and field widths.
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int ENTRY_ID_W  = 16;
    localparam int PRIO_W      = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Request kinds.
    typedef enum logic [1:0] {
        K_INSERT  = 2'd0,
        K_EXTRACT = 2'd1,
        K_REMOVE  = 2'd2,
        K_CHANGE  = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One stored entry.
    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // Request-wide control broadcast to every cell.
    typedef struct packed {
        logic   rm_en;      // an entry leaves the list
        logic   match_any;  // the first occupied entry is the one that leaves
        logic   ins_en;     // an entry is placed into the list
        logic   commit;     // the request changes the stored state
        entry_t new_entry;
    } ctrl_t;

    // Chain signals passed from a cell towards the tail.
    typedef struct packed {
        logic   le_adj;     // slot holds a lower-or-equal entry after removal
        logic   seen;       // the leaving entry lies at or before this slot
        entry_t entry;
        entry_t acc;        // the leaving entry, once passed
    } fwd_t;

    // Chain signals passed from a cell towards the head.
    typedef struct packed {
        logic   le;
        entry_t entry;
    } bwd_t;

    // One result transaction.
    typedef struct packed {
        status_t              status;
        logic [ENTRY_ID_W-1:0] id;
        logic [PRIO_W-1:0]    prio;
        logic [CNT_W-1:0]     occ;
    } rsp_t;

endpackage

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one slot of the list and picks its next entry from its neighbours.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic           clk,
    input  logic           occ,
    input  spq_pkg::ctrl_t ctrl,
    input  spq_pkg::fwd_t  fwd_in,
    input  spq_pkg::bwd_t  bwd_in,
    output spq_pkg::fwd_t  fwd_out,
    output spq_pkg::bwd_t  bwd_out
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   match;
    logic   hit;
    logic   seen;
    logic   le;
    logic   le_adj;

    // Compare this slot with the request.
    always_comb
    begin
        match  = occ && ctrl.rm_en && (ctrl.match_any || entry_reg.id == ctrl.new_entry.id);
        hit    = match && !fwd_in.seen;
        seen   = fwd_in.seen || match;
        le     = occ && (entry_reg.prio <= ctrl.new_entry.prio);
        le_adj = ctrl.ins_en ? (seen ? bwd_in.le : le) : 1'b1;
    end

    // Pick the entry this slot holds after the request.
    always_comb
    begin
        if (le_adj)
        begin
            entry_next = seen ? bwd_in.entry : entry_reg;
        end
        else if (fwd_in.le_adj)
        begin
            entry_next = ctrl.new_entry;
        end
        else
        begin
            entry_next = fwd_in.seen ? entry_reg : fwd_in.entry;
        end
    end

    // Slot storage, updated only by requests that succeed.
    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            entry_reg <= entry_next;
        end
    end

    // Chain outputs.
    always_comb
    begin
        fwd_out.le_adj = le_adj;
        fwd_out.seen   = seen;
        fwd_out.entry  = entry_reg;
        fwd_out.acc    = fwd_in.acc | (hit ? entry_reg : '0);
        bwd_out.le     = le;
        bwd_out.entry  = entry_reg;
    end

endmodule

[sv/spq_rsp_buf.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue result buffer
// Two-deep buffer that decouples the result channel from the request side.
// ----------------------------------------------------------------------------
module spq_rsp_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spq_pkg::rsp_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output spq_pkg::rsp_t head
);
    import spq_pkg::*;

    rsp_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

endmodule

[sv/sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Keeps up to QUEUE_DEPTH entries sorted by priority in a row of cells and
// serves insert, extract, remove and priority change requests.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  request   req_valid / req_stall  kind, entry_id, priority_req
//  result    rsp_valid / rsp_stall  status, out_id, out_priority, occupancy
//
// One request is taken per cycle while req_stall is low; its result is ready in the
// following cycle. Every cell compares and shifts in the same cycle, so the row
// of cells forms one combinational path. A two-deep result buffer lets requests continue
// while a result waits; req_stall rises only when both slots are taken.
// Reset clears the entry count and the buffer; slot contents are not reset.
//
module sorted_priority_queue_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    kind,
    input  logic [spq_pkg::ENTRY_ID_W-1:0] entry_id,
    input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic [spq_pkg::ENTRY_ID_W-1:0] out_id,
    output logic [spq_pkg::PRIO_W-1:0]    out_priority,
    output logic [spq_pkg::CNT_W-1:0]     occupancy
);
    import spq_pkg::*;

    logic             count_full;
    logic             accept;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    kind_t            req_kind;
    ctrl_t            ctrl;
    status_t          res_status;
    entry_t           res_entry;
    rsp_t             rsp_new;
    rsp_t             rsp_head;
    logic             found;
    entry_t           removed;
    fwd_t             fwd [QUEUE_DEPTH+1];
    bwd_t             bwd [QUEUE_DEPTH+1];

    assign accept     = req_valid && !req_stall;
    assign req_kind   = kind_t'(kind);
    assign count_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign found      = fwd[QUEUE_DEPTH].seen;
    assign removed    = fwd[QUEUE_DEPTH].acc;

    // Request decode: status, control for the cells and the next count.
    always_comb
    begin
        ctrl.rm_en         = 1'b0;
        ctrl.match_any     = 1'b0;
        ctrl.ins_en        = 1'b0;
        ctrl.new_entry.id  = ID_BITS'(entry_id);
        ctrl.new_entry.prio = priority_req;
        res_status         = ST_OK;
        res_entry          = '0;
        count_next         = count_reg;
        unique case (req_kind)
            K_INSERT:
            begin
                ctrl.ins_en = 1'b1;
                if (count_full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_entry  = ctrl.new_entry;
                    count_next = count_reg + 1'b1;
                end
            end
            K_EXTRACT:
            begin
                ctrl.rm_en     = 1'b1;
                ctrl.match_any = 1'b1;
                if (count_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_entry  = removed;
                    count_next = count_reg - 1'b1;
                end
            end
            K_REMOVE:
            begin
                ctrl.rm_en = 1'b1;
                if (count_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else if (!found)
                begin
                    res_status = ST_NOT_FOUND;
                end
                else
                begin
                    res_entry  = removed;
                    count_next = count_reg - 1'b1;
                end
            end
            K_CHANGE:
            begin
                ctrl.rm_en  = 1'b1;
                ctrl.ins_en = 1'b1;
                if (count_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else if (!found)
                begin
                    res_status = ST_NOT_FOUND;
                end
                else
                begin
                    res_entry = ctrl.new_entry;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
        ctrl.commit = accept && (res_status == ST_OK);
    end

    // Entry count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Ends of the cell chain.
    assign fwd[0] = '{le_adj: 1'b1, seen: 1'b0, entry: '0, acc: '0};
    assign bwd[QUEUE_DEPTH] = '{le: 1'b0, entry: bwd[QUEUE_DEPTH-1].entry};

    // Row of cells, head at index zero.
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        spq_cell u_cell (
            .clk     (clk),
            .occ     (CNT_W'(g) < count_reg),
            .ctrl    (ctrl),
            .fwd_in  (fwd[g]),
            .bwd_in  (bwd[g+1]),
            .fwd_out (fwd[g+1]),
            .bwd_out (bwd[g])
        );
    end

    // Result transaction.
    always_comb
    begin
        rsp_new.status = res_status;
        rsp_new.id     = ENTRY_ID_W'(res_entry.id);
        rsp_new.prio   = res_entry.prio;
        rsp_new.occ    = count_next;
    end

    spq_rsp_buf u_rsp_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (rsp_new),
        .pop       (rsp_valid && !rsp_stall),
        .full      (req_stall),
        .not_empty (rsp_valid),
        .head      (rsp_head)
    );

    assign status       = rsp_head.status;
    assign out_id       = rsp_head.id;
    assign out_priority = rsp_head.prio;
    assign occupancy    = rsp_head.occ;

`ifndef ASSERT_OFF
    // The count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // The count moves by at most one per request.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)
        || ($past(count_reg) == count_reg + 1'b1))
        else $error("entry count jumped");

    // A failed request reports no entry.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (out_id == '0) && (out_priority == '0))
        else $error("failed request reports an entry");

    // An empty status comes only from an empty queue.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status with entries held");
`endif

endmodule

[tb/spq_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue result checker
// Watches the request and result channels of the queue unit. Each accepted
// request updates a private copy of the sorted list and yields the result it
// should cause. Each accepted result is compared field by field with the
// oldest pending one.
// ----------------------------------------------------------------------------
module spq_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [1:0]                    kind,
    input  logic [spq_pkg::ENTRY_ID_W-1:0] entry_id,
    input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [1:0]                    status,
    input  logic [spq_pkg::ENTRY_ID_W-1:0] out_id,
    input  logic [spq_pkg::PRIO_W-1:0]    out_priority,
    input  logic [spq_pkg::CNT_W-1:0]     occupancy,
    output int                            fail_count,
    output int                            outstanding
);

    import spq_pkg::*;

    // Private copy of the sorted list, head at index 0.
    entry_t list_slots [QUEUE_DEPTH];
    int     list_count;

    // Results still to come, oldest first.
    rsp_t   pending_results [$];
    rsp_t   oldest;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        list_count  = 0;
    end

    // Place an entry behind every entry whose priority is lower or equal.
    function automatic void place_sorted(input entry_t e);
        int pos;
        int k;
        pos = 0;
        while (pos < list_count && list_slots[pos].prio <= e.prio)
            pos++;
        for (k = list_count; k > pos; k--)
            list_slots[k] = list_slots[k - 1];
        list_slots[pos] = e;
        list_count++;
    endfunction

    // Close the gap left by the entry at the given slot.
    function automatic void drop_slot(input int pos);
        int k;
        for (k = pos; k + 1 < list_count; k++)
            list_slots[k] = list_slots[k + 1];
        list_count--;
    endfunction

    // Apply one request to the list and return the result it causes.
    function automatic rsp_t queue_outcome(input kind_t k,
                                           input logic [ENTRY_ID_W-1:0] id,
                                           input logic [PRIO_W-1:0] prio);
        rsp_t   res;
        entry_t e;
        int     pos;
        res        = '0;
        res.status = ST_OK;
        e.id       = id[ID_BITS-1:0];
        e.prio     = prio;
        if (k == K_INSERT)
        begin
            if (list_count >= QUEUE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                place_sorted(e);
                res.id   = ENTRY_ID_W'(e.id);
                res.prio = prio;
            end
        end
        else if (list_count == 0)
            res.status = ST_EMPTY;
        else if (k == K_EXTRACT)
        begin
            res.id   = ENTRY_ID_W'(list_slots[0].id);
            res.prio = list_slots[0].prio;
            drop_slot(0);
        end
        else
        begin
            // Only the first entry with the id, nearest the head, is affected.
            pos = 0;
            while (pos < list_count && list_slots[pos].id != e.id)
                pos++;
            if (pos == list_count)
                res.status = ST_NOT_FOUND;
            else if (k == K_REMOVE)
            begin
                res.id   = ENTRY_ID_W'(list_slots[pos].id);
                res.prio = list_slots[pos].prio;
                drop_slot(pos);
            end
            else
            begin
                // A change always re-inserts behind equals, even if unchanged.
                drop_slot(pos);
                place_sorted(e);
                res.id   = ENTRY_ID_W'(e.id);
                res.prio = prio;
            end
        end
        res.occ = CNT_W'(list_count);
        return res;
    endfunction

    function automatic void report_mismatch(input string field,
                                            input logic [31:0] want,
                                            input logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
        fail_count++;
    endfunction

    // Compare results first, then record the request taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_count = 0;
            pending_results.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, status %0d id 0x%0h",
                             $time, status, out_id);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (oldest.status !== status)
                        report_mismatch("status", 32'(oldest.status), 32'(status));
                    if (oldest.id !== out_id)
                        report_mismatch("out_id", 32'(oldest.id), 32'(out_id));
                    if (oldest.prio !== out_priority)
                        report_mismatch("out_priority", oldest.prio, out_priority);
                    if (oldest.occ !== occupancy)
                        report_mismatch("occupancy", 32'(oldest.occ), 32'(occupancy));
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(queue_outcome(kind_t'(kind), entry_id,
                                                        priority_req));
        end
        outstanding = pending_results.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives a directed run through the corner cases followed by random request
// traffic in fill, drain and mixed phases, with bursty requests, a random
// result stall pattern and one long result hold-off. The result checker does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    import spq_pkg::*;

    localparam int RANDOM_REQUESTS = 730;
    localparam int CYCLE_LIMIT     = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            kind;
    logic [ENTRY_ID_W-1:0] entry_id;
    logic [PRIO_W-1:0]     priority_req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [1:0]            status;
    logic [ENTRY_ID_W-1:0] out_id;
    logic [PRIO_W-1:0]     out_priority;
    logic [CNT_W-1:0]      occupancy;

    int fail_count;
    int outstanding;
    int burst_left;
    int cycle_count;
    int rx_cycles;
    bit long_hold_done;

    sorted_priority_queue_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .entry_id     (entry_id),
        .priority_req (priority_req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    spq_result_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .entry_id     (entry_id),
        .priority_req (priority_req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .occupancy    (occupancy),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request and hold it until the unit takes it.
    task automatic offer_request(input kind_t k, input logic [ENTRY_ID_W-1:0] id,
                                 input logic [PRIO_W-1:0] prio);
        req_valid    <= 1'b1;
        kind         <= k;
        entry_id     <= id;
        priority_req <= prio;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Between bursts the sender may drop valid for a random number of cycles.
    task automatic burst_gap();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Result receiver: stall patterns of random length, and one long hold-off
    // so that the result buffer fills and the request side stalls.
    initial
    begin
        int mode;
        int len;
        rsp_stall      = 1'b0;
        rx_cycles      = 0;
        long_hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            repeat (len)
            begin
                @(posedge clk);
                rx_cycles++;
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= 1'($urandom_range(0, 1));
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
            if (!long_hold_done && rx_cycles > 250)
            begin
                @(posedge clk);
                rsp_stall <= 1'b1;
                repeat (60) @(posedge clk);
                long_hold_done = 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int    i;
        int    r;
        int    phase;
        kind_t k;
        logic [ENTRY_ID_W-1:0] id;
        logic [PRIO_W-1:0]     prio;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        kind         = K_INSERT;
        entry_id     = '0;
        priority_req = '0;
        burst_left   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: requests on an empty queue.
        offer_request(K_EXTRACT, 16'h0000, 32'h0000_0000);
        burst_gap();
        offer_request(K_REMOVE, 16'h0003, 32'h0000_0000);
        burst_gap();
        offer_request(K_CHANGE, 16'h0003, 32'h0000_0010);
        burst_gap();
        // Extreme fields, equal priorities and a repeated id.
        offer_request(K_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        burst_gap();
        offer_request(K_INSERT, 16'h0000, 32'h0000_0000);
        burst_gap();
        offer_request(K_INSERT, 16'h0005, 32'd100);
        burst_gap();
        offer_request(K_INSERT, 16'h0005, 32'd100);
        burst_gap();
        offer_request(K_INSERT, 16'h0007, 32'd100);
        burst_gap();
        // Unknown id for remove and change.
        offer_request(K_REMOVE, 16'h0009, 32'h0000_0000);
        burst_gap();
        offer_request(K_CHANGE, 16'h0009, 32'd50);
        burst_gap();
        // Change to the same priority moves the entry behind its equals.
        offer_request(K_CHANGE, 16'h0005, 32'd100);
        burst_gap();
        offer_request(K_REMOVE, 16'h0005, 32'h0000_0000);
        burst_gap();
        // Fill the queue, then insert once more into a full queue.
        for (i = 0; i < 12; i++)
        begin
            offer_request(K_INSERT, 16'(1 << i), 32'(1000 - 40 * i));
            burst_gap();
        end
        offer_request(K_INSERT, 16'h8000, 32'h0000_0001);
        burst_gap();
        offer_request(K_EXTRACT, 16'h0000, 32'h0000_0000);

        // Random traffic in phases that lean to filling, draining or neither.
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            burst_gap();
            phase = (i / 60) % 3;
            r     = $urandom_range(0, 99);
            case (phase)
                0: k = (r < 70) ? K_INSERT : (r < 80) ? K_EXTRACT :
                       (r < 90) ? K_REMOVE : K_CHANGE;
                1: k = (r < 20) ? K_INSERT : (r < 60) ? K_EXTRACT :
                       (r < 80) ? K_REMOVE : K_CHANGE;
                default: k = (r < 40) ? K_INSERT : (r < 60) ? K_EXTRACT :
                             (r < 80) ? K_REMOVE : K_CHANGE;
            endcase
            // A small id pool makes remove and change find their entries.
            id = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 11))
                                              : 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 45)
                prio = $urandom_range(0, 7);
            else if (r < 75)
                prio = $urandom();
            else if (r < 87)
                prio = 32'h0000_0000;
            else
                prio = 32'hFFFF_FFFF - $urandom_range(0, 3);
            offer_request(k, id, prio);
        end
        req_valid <= 1'b0;

        // Drain the outstanding results, then allow for the result latency.
        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
